[rtl/ipsp_pkg.sv]
// Package for the patch stream parser: phase and status codes, format codes,
// magic and terminator constants, and the result word type.
// No dependencies; every other file of the block but ipsp_if imports it.
package ipsp_pkg;

  localparam int unsigned RecordCap = 4096;
  localparam int unsigned CountW    = 17;

  // Parser phases.
  localparam logic [2:0] PH_MAGIC = 3'd0;
  localparam logic [2:0] PH_OFF   = 3'd1;
  localparam logic [2:0] PH_SIZE  = 3'd2;
  localparam logic [2:0] PH_RUN   = 3'd3;
  localparam logic [2:0] PH_FILL  = 3'd4;
  localparam logic [2:0] PH_DATA  = 3'd5;
  localparam logic [2:0] PH_DRAIN = 3'd6;

  // Summary status codes.
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_MAGIC     = 3'd1;
  localparam logic [2:0] ST_TRUNC_HDR = 3'd2;
  localparam logic [2:0] ST_TRUNC_RUN = 3'd3;
  localparam logic [2:0] ST_TRUNC_DAT = 3'd4;
  localparam logic [2:0] ST_CAP       = 3'd5;
  localparam logic [2:0] ST_NO_TERM   = 3'd6;

  // Patch formats.
  localparam logic [1:0] FMT_NONE    = 2'd0;
  localparam logic [1:0] FMT_CLASSIC = 2'd1;
  localparam logic [1:0] FMT_WIDE    = 2'd2;

  // Item kinds.
  localparam logic KIND_RECORD  = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  localparam logic [31:0] TERM_CLASSIC = 32'h0045_4F46;  // "EOF"
  localparam logic [31:0] TERM_WIDE    = 32'h4545_4F46;  // "EEOF"
  localparam logic [CountW-1:0] CAP_COUNT = CountW'(RecordCap);

  typedef struct packed {
    logic        item_kind;
    logic [31:0] record_offset;
    logic [15:0] record_length;
    logic        run_record;
    logic [7:0]  fill_value;
    logic [2:0]  parse_status;
    logic [1:0]  patch_format;
    logic [31:0] lowest_offset;
    logic [32:0] highest_end;
    logic [31:0] byte_total;
    logic [CountW-1:0] records_seen;
  } res_t;

  // Results produced by one accepted byte: none, one or two.
  typedef struct packed {
    logic [1:0] count;
    res_t       first;
    res_t       second;
  } push_t;

  // "PATCH"
  function automatic logic [7:0] magic_classic(input logic [2:0] idx);
    logic [7:0] v;
    unique case (idx)
      3'd0:    v = 8'h50;
      3'd1:    v = 8'h41;
      3'd2:    v = 8'h54;
      3'd3:    v = 8'h43;
      default: v = 8'h48;
    endcase
    return v;
  endfunction

  // "IPS32"
  function automatic logic [7:0] magic_wide(input logic [2:0] idx);
    logic [7:0] v;
    unique case (idx)
      3'd0:    v = 8'h49;
      3'd1:    v = 8'h50;
      3'd2:    v = 8'h53;
      3'd3:    v = 8'h33;
      default: v = 8'h32;
    endcase
    return v;
  endfunction

endpackage

[rtl/ipsp_if.sv]
// Valid/ready channel interfaces of the patch stream parser: the byte input
// and the result output. The field widths are written out, not taken from ipsp_pkg.
interface ipsp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_value;
  logic       last_byte;

  modport source (output valid, output byte_value, output last_byte, input ready);
  modport sink (input valid, input byte_value, input last_byte, output ready);
endinterface

interface ipsp_out_if;
  logic        valid;
  logic        ready;
  logic        item_kind;
  logic [31:0] record_offset;
  logic [15:0] record_length;
  logic        run_record;
  logic [7:0]  fill_value;
  logic [2:0]  parse_status;
  logic [1:0]  patch_format;
  logic [31:0] lowest_offset;
  logic [32:0] highest_end;
  logic [31:0] byte_total;
  logic [16:0] records_seen;

  modport source (
    output valid, output item_kind, output record_offset, output record_length,
    output run_record, output fill_value, output parse_status, output patch_format,
    output lowest_offset, output highest_end, output byte_total, output records_seen,
    input ready
  );
  modport sink (
    input valid, input item_kind, input record_offset, input record_length,
    input run_record, input fill_value, input parse_status, input patch_format,
    input lowest_offset, input highest_end, input byte_total, input records_seen,
    output ready
  );
endinterface

[rtl/ips_patch_stream_parser.sv]
// Streaming parser for classic and 32-bit patch files, one byte per word.
// Throughput: one byte per cycle while the result queue has room; a byte that
// yields two words (a record and a summary) writes both into the four-word queue.
// A result word is written into the queue registers and leaves after any earlier words.
// Reset (rst, synchronous, active high) returns the parser to the magic
// phase with cleared statistics and empties the result queue.
module ips_patch_stream_parser (
  input  logic       clk,
  input  logic       rst,
  ipsp_in_if.sink    patch,
  ipsp_out_if.source result
);
  import ipsp_pkg::*;

  push_t push;
  logic  room;
  logic  accept;

  // A byte is taken whenever the queue can hold the two words it may
  // produce, so the input keeps flowing while earlier results wait. No byte
  // is taken while reset is held.
  assign patch.ready = room && !rst;
  assign accept      = patch.valid && patch.ready;

  // Magic check, field assembly, record bookkeeping and summary building
  // all happen in the cycle the byte is accepted.
  ipsp_core u_core (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .byte_value (patch.byte_value),
    .last_byte  (patch.last_byte),
    .push       (push)
  );

  // Result words leave one per cycle from the queue registers while the receiver is ready.
  ipsp_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .room   (room),
    .result (result)
  );

endmodule

[rtl/ipsp_core.sv]
// Parser state and per-byte update logic. Produces up to two result words
// per accepted byte. Depends on ipsp_pkg.
module ipsp_core (
  input  logic           clk,
  input  logic           rst,
  input  logic           accept,
  input  logic [7:0]     byte_value,
  input  logic           last_byte,
  output ipsp_pkg::push_t push
);
  import ipsp_pkg::*;

  logic [2:0]  phase, phase_next;
  logic [15:0] field_counter, field_counter_next;
  logic [1:0]  format_reg, format_reg_next;
  logic [1:0]  magic_match, magic_match_next;
  logic [31:0] offset_accum, offset_accum_next;
  logic [15:0] size_accum, size_accum_next;
  logic [31:0] min_reg, min_reg_next;
  logic [32:0] max_reg, max_reg_next;
  logic [31:0] total_reg, total_reg_next;
  logic [CountW-1:0] count_reg, count_reg_next;

  logic        emit_rec, emit_sum, rec_run;
  logic [7:0]  rec_fill;
  logic [2:0]  sum_status;
  logic [15:0] cnt_inc, cnt_dec;
  logic [2:0]  magic_idx;
  logic [1:0]  mm;
  logic [31:0] off_new;
  logic [15:0] size_new;
  logic [15:0] off_len;
  logic [31:0] term;
  logic [32:0] rec_end;
  res_t        rec_item, sum_item;

  always_comb begin
    phase_next         = phase;
    field_counter_next = field_counter;
    format_reg_next    = format_reg;
    magic_match_next   = magic_match;
    offset_accum_next  = offset_accum;
    size_accum_next    = size_accum;
    emit_rec           = 1'b0;
    emit_sum           = 1'b0;
    rec_run            = 1'b0;
    rec_fill           = 8'd0;
    sum_status         = ST_OK;

    cnt_inc   = field_counter + 16'd1;
    cnt_dec   = (field_counter != 16'd0) ? field_counter - 16'd1 : 16'd0;
    magic_idx = (field_counter < 16'd5) ? field_counter[2:0] : 3'd4;
    mm        = magic_match & {byte_value == magic_wide(magic_idx),
                               byte_value == magic_classic(magic_idx)};
    off_new   = {offset_accum[23:0], byte_value};
    size_new  = {size_accum[7:0], byte_value};
    off_len   = (format_reg == FMT_WIDE) ? 16'd4 : 16'd3;
    term      = (format_reg == FMT_WIDE) ? TERM_WIDE : TERM_CLASSIC;

    unique case (phase)
      PH_MAGIC: begin
        field_counter_next = cnt_inc;
        magic_match_next   = mm;
        if (mm == 2'b00) begin
          emit_sum   = 1'b1;
          sum_status = ST_MAGIC;
        end else if (cnt_inc >= 16'd5) begin
          format_reg_next    = mm[0] ? FMT_CLASSIC : FMT_WIDE;
          phase_next         = PH_OFF;
          field_counter_next = 16'd0;
          offset_accum_next  = 32'd0;
          if (last_byte) begin
            emit_sum   = 1'b1;
            sum_status = ST_NO_TERM;
          end
        end else if (last_byte) begin
          emit_sum   = 1'b1;
          sum_status = ST_MAGIC;
        end
      end
      PH_OFF: begin
        offset_accum_next  = off_new;
        field_counter_next = cnt_inc;
        if (cnt_inc >= off_len && off_new == term) begin
          emit_sum   = 1'b1;
          sum_status = ST_OK;
        end else begin
          if (cnt_inc >= off_len) begin
            phase_next         = PH_SIZE;
            field_counter_next = 16'd0;
            size_accum_next    = 16'd0;
          end
          if (last_byte) begin
            emit_sum   = 1'b1;
            sum_status = ST_TRUNC_HDR;
          end
        end
      end
      PH_SIZE: begin
        size_accum_next    = size_new;
        field_counter_next = cnt_inc;
        if (cnt_inc >= 16'd2) begin
          if (count_reg >= CAP_COUNT) begin
            emit_sum   = 1'b1;
            sum_status = ST_CAP;
          end else if (size_new == 16'd0) begin
            phase_next         = PH_RUN;
            field_counter_next = 16'd0;
            if (last_byte) begin
              emit_sum   = 1'b1;
              sum_status = ST_TRUNC_RUN;
            end
          end else begin
            phase_next         = PH_DATA;
            field_counter_next = size_new;
            if (last_byte) begin
              emit_sum   = 1'b1;
              sum_status = ST_TRUNC_DAT;
            end
          end
        end else if (last_byte) begin
          emit_sum   = 1'b1;
          sum_status = ST_TRUNC_HDR;
        end
      end
      PH_RUN: begin
        size_accum_next    = size_new;
        field_counter_next = cnt_inc;
        if (cnt_inc >= 16'd2) begin
          phase_next = PH_FILL;
        end
        if (last_byte) begin
          emit_sum   = 1'b1;
          sum_status = ST_TRUNC_RUN;
        end
      end
      PH_FILL: begin
        emit_rec = 1'b1;
        rec_run  = 1'b1;
        rec_fill = byte_value;
        if (last_byte) begin
          emit_sum   = 1'b1;
          sum_status = ST_NO_TERM;
        end
      end
      PH_DATA: begin
        field_counter_next = cnt_dec;
        if (cnt_dec == 16'd0) begin
          emit_rec = 1'b1;
          if (last_byte) begin
            emit_sum   = 1'b1;
            sum_status = ST_NO_TERM;
          end
        end else if (last_byte) begin
          emit_sum   = 1'b1;
          sum_status = ST_TRUNC_DAT;
        end
      end
      default: begin
        // Draining after a summary: nothing to do until the final byte.
      end
    endcase

    // A completed record folds into the running statistics.
    rec_end        = {1'b0, offset_accum} + {17'd0, size_accum};
    min_reg_next   = min_reg;
    max_reg_next   = max_reg;
    total_reg_next = total_reg;
    count_reg_next = count_reg;
    if (emit_rec) begin
      if (offset_accum < min_reg) begin
        min_reg_next = offset_accum;
      end
      if (rec_end > max_reg) begin
        max_reg_next = rec_end;
      end
      total_reg_next     = total_reg + {16'd0, size_accum};
      count_reg_next     = count_reg + CountW'(1);
      phase_next         = PH_OFF;
      field_counter_next = 16'd0;
      offset_accum_next  = 32'd0;
      size_accum_next    = 16'd0;
    end

    rec_item               = '0;
    rec_item.item_kind     = KIND_RECORD;
    rec_item.record_offset = offset_accum;
    rec_item.record_length = size_accum;
    rec_item.run_record    = rec_run;
    rec_item.fill_value    = rec_fill;

    sum_item               = '0;
    sum_item.item_kind     = KIND_SUMMARY;
    sum_item.parse_status  = sum_status;
    sum_item.patch_format  = format_reg_next;
    sum_item.lowest_offset = (count_reg_next == '0) ? 32'd0 : min_reg_next;
    sum_item.highest_end   = max_reg_next;
    sum_item.byte_total    = total_reg_next;
    sum_item.records_seen  = count_reg_next;

    if (emit_sum) begin
      phase_next = PH_DRAIN;
    end

    // The final byte always returns the parser to its reset state.
    if (last_byte && (emit_sum || phase == PH_DRAIN)) begin
      phase_next         = PH_MAGIC;
      field_counter_next = 16'd0;
      format_reg_next    = FMT_NONE;
      magic_match_next   = 2'b11;
      offset_accum_next  = 32'd0;
      size_accum_next    = 16'd0;
      min_reg_next       = '1;
      max_reg_next       = 33'd0;
      total_reg_next     = 32'd0;
      count_reg_next     = '0;
    end

    push.count  = accept ? {emit_rec & emit_sum, emit_rec ^ emit_sum} : 2'd0;
    push.first  = emit_rec ? rec_item : sum_item;
    push.second = sum_item;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_MAGIC;
      field_counter <= 16'd0;
      format_reg    <= FMT_NONE;
      magic_match   <= 2'b11;
      offset_accum  <= 32'd0;
      size_accum    <= 16'd0;
      min_reg       <= '1;
      max_reg       <= 33'd0;
      total_reg     <= 32'd0;
      count_reg     <= '0;
    end else if (accept) begin
      phase         <= phase_next;
      field_counter <= field_counter_next;
      format_reg    <= format_reg_next;
      magic_match   <= magic_match_next;
      offset_accum  <= offset_accum_next;
      size_accum    <= size_accum_next;
      min_reg       <= min_reg_next;
      max_reg       <= max_reg_next;
      total_reg     <= total_reg_next;
      count_reg     <= count_reg_next;
    end
  end

endmodule

[rtl/ipsp_queue.sv]
// Four-word result queue: takes up to two words per cycle from the parser
// and hands one word per cycle to the output channel while it is ready. Depends on ipsp_pkg.
module ipsp_queue (
  input  logic            clk,
  input  logic            rst,
  input  ipsp_pkg::push_t push,
  output logic            room,
  ipsp_out_if.source      result
);
  import ipsp_pkg::*;

  res_t       mem [4];
  logic [1:0] wr_ptr, rd_ptr;
  logic [2:0] count, count_next;
  logic       pop;
  res_t       head;

  assign pop        = result.valid && result.ready;
  assign count_next = count + {1'b0, push.count} - {2'b00, pop};
  // Room for the worst case of two words from the next byte.
  assign room       = (count <= 3'd2);
  assign head       = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 2'd0;
      rd_ptr <= 2'd0;
      count  <= 3'd0;
    end else begin
      wr_ptr <= wr_ptr + push.count;
      rd_ptr <= rd_ptr + {1'b0, pop};
      count  <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      mem[wr_ptr] <= push.first;
    end
    if (push.count == 2'd2) begin
      mem[wr_ptr + 2'd1] <= push.second;
    end
  end

  assign result.valid         = (count != 3'd0);
  assign result.item_kind     = head.item_kind;
  assign result.record_offset = head.record_offset;
  assign result.record_length = head.record_length;
  assign result.run_record    = head.run_record;
  assign result.fill_value    = head.fill_value;
  assign result.parse_status  = head.parse_status;
  assign result.patch_format  = head.patch_format;
  assign result.lowest_offset = head.lowest_offset;
  assign result.highest_end   = head.highest_end;
  assign result.byte_total    = head.byte_total;
  assign result.records_seen  = head.records_seen;

endmodule

[tb/ipsp_tb_pkg.sv]
// Test support for the patch stream parser: the byte-list type, the magic
// strings and a result tracker that predicts and checks every result word.
// Depends on ipsp_pkg for the result word type and the code constants.
package ipsp_tb_pkg;
  import ipsp_pkg::*;

  typedef logic [7:0] byte_q_t[$];

  localparam logic [39:0] MAGIC_CLASSIC = "PATCH";
  localparam logic [39:0] MAGIC_WIDE    = "IPS32";

  // Tracks the parser state for each accepted byte and keeps the result
  // words that are still due, oldest first.
  class patch_parse_tracker;
    res_t        due_words[$];
    int          errors;
    int          words_checked;
    logic [2:0]  phase;
    logic [15:0] fcount;
    logic [1:0]  fmt;
    logic [1:0]  cand;
    logic [31:0] off_acc;
    logic [15:0] size_acc;
    logic [31:0] min_off;
    logic [32:0] max_end;
    logic [31:0] total;
    logic [16:0] nrec;

    function new();
      errors = 0;
      words_checked = 0;
      rearm();
    endfunction

    function void rearm();
      phase    = PH_MAGIC;
      fcount   = '0;
      fmt      = FMT_NONE;
      cand     = 2'b11;
      off_acc  = '0;
      size_acc = '0;
      min_off  = '1;
      max_end  = '0;
      total    = '0;
      nrec     = '0;
    endfunction

    function void add_record(logic run, logic [7:0] fill);
      res_t        r;
      logic [32:0] reach;
      r = '0;
      reach = {1'b0, off_acc} + 33'(size_acc);
      r.item_kind     = KIND_RECORD;
      r.record_offset = off_acc;
      r.record_length = size_acc;
      r.run_record    = run;
      r.fill_value    = fill;
      due_words.push_back(r);
      if (off_acc < min_off) min_off = off_acc;
      if (reach > max_end) max_end = reach;
      total    = total + 32'(size_acc);
      nrec     = nrec + 1'b1;
      phase    = PH_OFF;
      fcount   = '0;
      off_acc  = '0;
      size_acc = '0;
    endfunction

    // Summary word; a file that ends on this byte re-arms, else the rest drains.
    function void close_file(logic [2:0] status, logic fin);
      res_t r;
      r = '0;
      r.item_kind     = KIND_SUMMARY;
      r.parse_status  = status;
      r.patch_format  = fmt;
      r.lowest_offset = (nrec == 0) ? 32'd0 : min_off;
      r.highest_end   = max_end;
      r.byte_total    = total;
      r.records_seen  = nrec;
      due_words.push_back(r);
      if (fin) rearm();
      else phase = PH_DRAIN;
    endfunction

    function void note_byte(logic [7:0] b, logic fin);
      int          idx;
      int          nb;
      logic [31:0] term;
      case (phase)
        PH_MAGIC: begin
          idx = (fcount < 16'd5) ? int'(fcount) : 4;
          if (b != MAGIC_CLASSIC[8*(4-idx) +: 8]) cand[0] = 1'b0;
          if (b != MAGIC_WIDE[8*(4-idx) +: 8]) cand[1] = 1'b0;
          fcount = fcount + 1'b1;
          if (cand == 2'b00) begin
            close_file(ST_MAGIC, fin);
          end else if (fcount >= 16'd5) begin
            fmt     = cand[0] ? FMT_CLASSIC : FMT_WIDE;
            phase   = PH_OFF;
            fcount  = '0;
            off_acc = '0;
            if (fin) close_file(ST_NO_TERM, 1'b1);
          end else if (fin) begin
            close_file(ST_MAGIC, 1'b1);
          end
        end
        PH_OFF: begin
          nb   = (fmt == FMT_WIDE) ? 4 : 3;
          term = (fmt == FMT_WIDE) ? TERM_WIDE : TERM_CLASSIC;
          off_acc = {off_acc[23:0], b};
          fcount  = fcount + 1'b1;
          if (fcount >= nb) begin
            if (off_acc == term) begin
              close_file(ST_OK, fin);
              return;
            end
            phase    = PH_SIZE;
            fcount   = '0;
            size_acc = '0;
          end
          if (fin) close_file(ST_TRUNC_HDR, 1'b1);
        end
        PH_SIZE: begin
          size_acc = {size_acc[7:0], b};
          fcount   = fcount + 1'b1;
          if (fcount >= 16'd2) begin
            // The record cap takes precedence over any truncation status.
            if (nrec >= RecordCap) begin
              close_file(ST_CAP, fin);
            end else if (size_acc == 16'd0) begin
              phase  = PH_RUN;
              fcount = '0;
              if (fin) close_file(ST_TRUNC_RUN, 1'b1);
            end else begin
              phase  = PH_DATA;
              fcount = size_acc;
              if (fin) close_file(ST_TRUNC_DAT, 1'b1);
            end
          end else if (fin) begin
            close_file(ST_TRUNC_HDR, 1'b1);
          end
        end
        PH_RUN: begin
          size_acc = {size_acc[7:0], b};
          fcount   = fcount + 1'b1;
          if (fcount >= 16'd2) phase = PH_FILL;
          if (fin) close_file(ST_TRUNC_RUN, 1'b1);
        end
        PH_FILL: begin
          add_record(1'b1, b);
          if (fin) close_file(ST_NO_TERM, 1'b1);
        end
        PH_DATA: begin
          if (fcount > 0) fcount = fcount - 1'b1;
          if (fcount == 16'd0) begin
            add_record(1'b0, 8'd0);
            if (fin) close_file(ST_NO_TERM, 1'b1);
          end else if (fin) begin
            close_file(ST_TRUNC_DAT, 1'b1);
          end
        end
        default: begin
          if (fin) rearm();
        end
      endcase
    endfunction

    function int due_count();
      return due_words.size();
    endfunction

    task report_mismatch(string what);
      errors++;
      $display("MISMATCH at %0t: %s", $time, what);
    endtask

    task check_result(res_t got);
      res_t want;
      string tag;
      tag = $sformatf("word %0d", words_checked);
      words_checked++;
      if (due_words.size() == 0) begin
        report_mismatch($sformatf("%s arrived with nothing due: %p", tag, got));
        return;
      end
      want = due_words.pop_front();
      if (got.item_kind !== want.item_kind)
        report_mismatch($sformatf("%s item_kind got %0h want %0h", tag,
                                  got.item_kind, want.item_kind));
      if (got.record_offset !== want.record_offset)
        report_mismatch($sformatf("%s record_offset got %0h want %0h", tag,
                                  got.record_offset, want.record_offset));
      if (got.record_length !== want.record_length)
        report_mismatch($sformatf("%s record_length got %0h want %0h", tag,
                                  got.record_length, want.record_length));
      if (got.run_record !== want.run_record)
        report_mismatch($sformatf("%s run_record got %0h want %0h", tag,
                                  got.run_record, want.run_record));
      if (got.fill_value !== want.fill_value)
        report_mismatch($sformatf("%s fill_value got %0h want %0h", tag,
                                  got.fill_value, want.fill_value));
      if (got.parse_status !== want.parse_status)
        report_mismatch($sformatf("%s parse_status got %0h want %0h", tag,
                                  got.parse_status, want.parse_status));
      if (got.patch_format !== want.patch_format)
        report_mismatch($sformatf("%s patch_format got %0h want %0h", tag,
                                  got.patch_format, want.patch_format));
      if (got.lowest_offset !== want.lowest_offset)
        report_mismatch($sformatf("%s lowest_offset got %0h want %0h", tag,
                                  got.lowest_offset, want.lowest_offset));
      if (got.highest_end !== want.highest_end)
        report_mismatch($sformatf("%s highest_end got %0h want %0h", tag,
                                  got.highest_end, want.highest_end));
      if (got.byte_total !== want.byte_total)
        report_mismatch($sformatf("%s byte_total got %0h want %0h", tag,
                                  got.byte_total, want.byte_total));
      if (got.records_seen !== want.records_seen)
        report_mismatch($sformatf("%s records_seen got %0h want %0h", tag,
                                  got.records_seen, want.records_seen));
    endtask

    task flag_missing();
      foreach (due_words[i])
        report_mismatch($sformatf("result never arrived: %p", due_words[i]));
      due_words.delete();
    endtask
  endclass

endpackage

[tb/ips_patch_stream_parser_test.sv]
// Top-level test of the patch stream parser: drives whole patch files a word
// at a time and checks every result word against the tracker's prediction.
// Depends on ipsp_pkg, ipsp_tb_pkg, the channel interfaces and the parser.
module ips_patch_stream_parser_test;
  timeunit 1ns;
  timeprecision 1ps;

  import ipsp_pkg::*;
  import ipsp_tb_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;

  ipsp_in_if  patch ();
  ipsp_out_if result ();

  ips_patch_stream_parser i_dut (
    .clk    (clk),
    .rst    (rst),
    .patch  (patch),
    .result (result)
  );

  patch_parse_tracker tracker = new();

  // Idle rates in percent. The sender rate is only used by the stimulus
  // process; the receiver rate is handed over with nonblocking writes.
  int send_idle_pct;
  int recv_idle_pct;

  // Receiver bookkeeping for the one long hold-off.
  int words_taken = 0;
  int stall_left  = 0;
  bit stall_done  = 1'b0;

  always #2 clk = ~clk;

  // Receiver. Result words are taken at the rising edge where valid and ready
  // are both high; the values read here are the ones from before the edge,
  // since the parser and this bench only change them with nonblocking writes.
  // After forty words the receiver holds off for a long stretch while the
  // sender keeps offering bytes, so the result queue fills and the byte input
  // must stall.
  always @(posedge clk) begin
    res_t got;
    if (rst) begin
      result.ready <= 1'b0;
    end else begin
      if (result.valid && result.ready) begin
        got.item_kind     = result.item_kind;
        got.record_offset = result.record_offset;
        got.record_length = result.record_length;
        got.run_record    = result.run_record;
        got.fill_value    = result.fill_value;
        got.parse_status  = result.parse_status;
        got.patch_format  = result.patch_format;
        got.lowest_offset = result.lowest_offset;
        got.highest_end   = result.highest_end;
        got.byte_total    = result.byte_total;
        got.records_seen  = result.records_seen;
        tracker.check_result(got);
        words_taken++;
      end
      if (stall_left > 0) begin
        stall_left--;
        result.ready <= 1'b0;
      end else if (!stall_done && words_taken >= 40) begin
        stall_done = 1'b1;
        stall_left = 400;
        result.ready <= 1'b0;
      end else begin
        result.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Offers one word and returns at the edge where it is accepted. Idle
  // cycles come before the word, so gaps land at every point of a file.
  // A valid that stays high between words gets only one write per step.
  task automatic send_byte(input logic [7:0] b, input logic fin);
    while ($urandom_range(99) < send_idle_pct) begin
      patch.valid <= 1'b0;
      @(posedge clk);
    end
    patch.valid      <= 1'b1;
    patch.byte_value <= b;
    patch.last_byte  <= fin;
    @(posedge clk);
    while (!patch.ready) @(posedge clk);
    tracker.note_byte(b, fin);
  endtask

  // Sends a whole file; the final word carries the last-byte flag.
  task automatic send_file(input byte_q_t img);
    foreach (img[i]) send_byte(img[i], i == img.size() - 1);
  endtask

  // Appends the low n bytes of v, most significant first.
  function automatic void push_be(ref byte_q_t img, input logic [31:0] v, input int n);
    for (int k = n - 1; k >= 0; k--) img.push_back(v[8*k +: 8]);
  endfunction

  // A random file. Most are well formed with random records, so the parser
  // gets deep into the record phases; some have a damaged magic, no
  // terminator, trailing bytes after the terminator, or are cut short at a
  // random point. A few are plain noise.
  function automatic byte_q_t random_patch();
    byte_q_t     img;
    logic        wide;
    logic [39:0] magic;
    logic [31:0] ofs;
    logic [15:0] len;
    int          n_rec;
    int          cut;
    if ($urandom_range(15) == 0) begin
      repeat ($urandom_range(1, 10)) img.push_back(8'($urandom));
      return img;
    end
    wide  = 1'($urandom_range(1));
    magic = wide ? MAGIC_WIDE : MAGIC_CLASSIC;
    push_be(img, magic[39:8], 4);
    img.push_back(magic[7:0]);
    if ($urandom_range(9) == 0) img[$urandom_range(4)] = 8'($urandom);
    n_rec = $urandom_range(6);
    repeat (n_rec) begin
      case ($urandom_range(7))
        0:       ofs = '0;
        1:       ofs = '1;
        default: ofs = $urandom;
      endcase
      push_be(img, ofs, wide ? 4 : 3);
      if ($urandom_range(3) == 0) begin
        // Run record: zero size, then a length and one fill byte.
        len = ($urandom_range(5) == 0) ? 16'hFFFF : 16'($urandom);
        push_be(img, 32'd0, 2);
        push_be(img, 32'(len), 2);
        img.push_back(8'($urandom));
      end else begin
        len = ($urandom_range(7) == 0) ? 16'($urandom_range(13, 60))
                                       : 16'($urandom_range(1, 12));
        push_be(img, 32'(len), 2);
        repeat (len) img.push_back(8'($urandom));
      end
    end
    if ($urandom_range(7) != 0) push_be(img, wide ? TERM_WIDE : TERM_CLASSIC, wide ? 4 : 3);
    if ($urandom_range(3) == 0) repeat ($urandom_range(1, 4)) img.push_back(8'($urandom));
    if ($urandom_range(3) == 0) begin
      cut = $urandom_range(img.size() - 1);
      img = img[0:cut];
    end
    return img;
  endfunction

  initial begin
    byte_q_t img;
    int      random_bytes;
    random_bytes      = 0;
    patch.valid       = 1'b0;
    patch.byte_value  = 8'd0;
    patch.last_byte   = 1'b0;
    result.ready      = 1'b0;
    send_idle_pct     = 37;
    recv_idle_pct     = 63;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed files. First a magic that rules out the 32-bit candidate on the
    // first byte and the classic one on the second, with one more word that the parser must ignore.
    img = '{8'h50, 8'h58, 8'hFF};
    send_file(img);
    // A 32-bit file with one run record at the top offset and the longest run
    // length, so the highest end needs its carry bit, then a proper
    // terminator on the final word.
    img = '{8'h49, 8'h50, 8'h53, 8'h33, 8'h32,
            8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'hA5,
            8'h45, 8'h45, 8'h4F, 8'h46};
    send_file(img);
    // A classic magic that ends on the final word: no terminator.
    img = '{8'h50, 8'h41, 8'h54, 8'h43, 8'h48};
    send_file(img);

    // Random files: first the sender idles less than the receiver, then the
    // other way round, then neither idles.
    while (random_bytes < 620) begin
      img = random_patch();
      random_bytes += img.size();
      send_file(img);
    end
    send_idle_pct = 63;
    recv_idle_pct <= 37;
    while (random_bytes < 1240) begin
      img = random_patch();
      random_bytes += img.size();
      send_file(img);
    end
    send_idle_pct = 0;
    recv_idle_pct <= 0;
    while (random_bytes < 1550) begin
      img = random_patch();
      random_bytes += img.size();
      send_file(img);
    end
    patch.valid <= 1'b0;

    // Let the last words drain.
    for (int w = 0; w < 5000 && tracker.due_count() > 0; w++) @(posedge clk);
    repeat (8) @(posedge clk);
    tracker.flag_missing();
    if (tracker.errors == 0) begin
      $display("ips_patch_stream_parser_test: clean");
    end else begin
      $display("ips_patch_stream_parser_test: errors");
    end
    $finish;
  end

  // Watchdog: the slowest correct run needs well under a tenth of this.
  initial begin
    #2ms;
    $display("ips_patch_stream_parser_test: errors");
    $finish;
  end

endmodule

[sim.f]
rtl/ipsp_pkg.sv
rtl/ipsp_if.sv
rtl/ipsp_core.sv
rtl/ipsp_queue.sv
rtl/ips_patch_stream_parser.sv
tb/ipsp_tb_pkg.sv
tb/ips_patch_stream_parser_test.sv
